FILE: hdl/hamming_set_nearness_unit_assert.svh
// assertion macros shared by the hamming set nearness checker
`ifndef HAMMING_SET_NEARNESS_UNIT_ASSERT_SVH
`define HAMMING_SET_NEARNESS_UNIT_ASSERT_SVH

// same-cycle implication
`define HSN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/hsn_pkg.sv
// shared types, constants and functions of the hamming set nearness unit
`timescale 1ns / 1ps
`default_nettype none
package hsn_pkg;

   localparam int VEC_BITS  = 64;
   localparam int MAX_SET   = 256;
   localparam int FRAC_BITS = 16;
   localparam int NCELL     = 8;

   localparam int LEN_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int ADDR_W    = $clog2(MAX_SET);
   localparam int CNT_W     = $clog2(MAX_SET + 1);
   localparam int SEQ_W     = $clog2(MAX_SET + NCELL);
   localparam int MIN_W     = $clog2(VEC_BITS + 1);
   localparam int SUM_W     = $clog2(MAX_SET * VEC_BITS + 1);
   localparam int PROD_W    = SUM_W + CNT_W;
   localparam int DD_W      = 2 * CNT_W;
   localparam int DEN_W     = DD_W + 1 + LEN_W;
   localparam int DIVD_W    = DEN_W + FRAC_BITS;
   localparam int STEP_W    = $clog2(DIVD_W);
   localparam int Q_W       = 23;

   localparam logic [MIN_W-1:0] MIN_INIT = '1;

   localparam logic [1:0] ACT_LOAD_A  = 2'd0;
   localparam logic [1:0] ACT_LOAD_B  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AFFINITY_MODE = 1'd1;

   typedef struct packed {
      logic [1:0]          action;
      logic [VEC_BITS-1:0] vector;
   } hsn_req_type;

   typedef struct packed {
      logic [1:0]     status;
      logic [Q_W-1:0] nearness;
   } hsn_rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                shift;
      logic [VEC_BITS-1:0] mask;
   } hsn_ctl_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic [VEC_BITS-1:0] src;
      logic                srcv;
      logic [VEC_BITS-1:0] dst;
      logic                dstv;
      logic [MIN_W-1:0]    min;
   } hsn_link_type;

   function automatic logic [MIN_W-1:0] popcount(input logic [VEC_BITS-1:0] v);
      logic [MIN_W-1:0] n;
      n = '0;
      for (int i = 0; i < VEC_BITS; i++) begin
         n = n + MIN_W'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
      logic [LEN_W-1:0] r;
      r = l;
      if (l == '0) begin
         r = LEN_W'(1);
      end else if (l > LEN_W'(VEC_BITS)) begin
         r = LEN_W'(VEC_BITS);
      end
      return r;
   endfunction

   function automatic logic [VEC_BITS-1:0] len_mask(input logic [LEN_W-1:0] l);
      logic [VEC_BITS-1:0] ones;
      ones = '1;
      return ones >> (VEC_BITS - int'(l));
   endfunction

endpackage
`default_nettype wire

FILE: hdl/hsn_cell.sv
// one cell: holds a source vector and its running least distance
`timescale 1ns / 1ps
`default_nettype none
module hsn_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hsn_pkg::hsn_ctl_type  ctl,
   input  wire hsn_pkg::hsn_link_type link_in,
   output hsn_pkg::hsn_link_type     link_out
);

   logic [hsn_pkg::VEC_BITS-1:0] src_ff;
   logic [hsn_pkg::VEC_BITS-1:0] dst_ff;
   logic [hsn_pkg::MIN_W-1:0]    min_ff;
   logic                         srcv_ff;
   logic                         dstv_ff;
   logic [hsn_pkg::MIN_W-1:0]    hdist;

   assign hdist = hsn_pkg::popcount((src_ff ^ link_in.dst) & ctl.mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         srcv_ff <= 1'b0;
         dstv_ff <= 1'b0;
      end else begin
         dstv_ff <= link_in.dstv;
         if (ctl.shift) begin
            srcv_ff <= link_in.srcv;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= link_in.dst;
      if (ctl.shift) begin
         src_ff <= link_in.src;
         min_ff <= link_in.min;
      end else if (link_in.dstv && (hdist < min_ff)) begin
         min_ff <= hdist;
      end
   end

   assign link_out.src  = src_ff;
   assign link_out.srcv = srcv_ff;
   assign link_out.dst  = dst_ff;
   assign link_out.dstv = dstv_ff;
   assign link_out.min  = min_ff;

endmodule
`default_nettype wire

FILE: hdl/hsn_cell_row.sv
// row of distance cells chained head to tail
`timescale 1ns / 1ps
`default_nettype none
module hsn_cell_row (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hsn_pkg::hsn_ctl_type  ctl,
   input  wire hsn_pkg::hsn_link_type head,
   output hsn_pkg::hsn_link_type     tail
);

   hsn_pkg::hsn_link_type [hsn_pkg::NCELL:0] chain;

   assign chain[0] = head;

   for (genvar g = 0; g < hsn_pkg::NCELL; g++) begin : g_cell
      hsn_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .link_in  (chain[g]),
         .link_out (chain[g+1])
      );
   end

   assign tail = chain[hsn_pkg::NCELL];

endmodule
`default_nettype wire

FILE: hdl/hsn_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module hsn_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hsn_pkg::DIVD_W-1:0]    dividend,
   input  wire logic [hsn_pkg::DEN_W-1:0]     divisor,
   output logic                               done,
   output logic [hsn_pkg::Q_W-1:0]            quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [hsn_pkg::STEP_W-1:0]    step_ff;
   logic [hsn_pkg::DEN_W-1:0]     rem_ff;
   logic [hsn_pkg::DEN_W-1:0]     rem_in;
   logic [hsn_pkg::DIVD_W-1:0]    dvd_ff;
   logic [hsn_pkg::DEN_W-1:0]     dsr_ff;
   logic [hsn_pkg::Q_W-1:0]       quo_ff;
   logic [hsn_pkg::DEN_W:0]       trial;
   logic [hsn_pkg::DEN_W:0]       diff;
   logic                          fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[hsn_pkg::DIVD_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = fits ? diff[hsn_pkg::DEN_W-1:0] : trial[hsn_pkg::DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= hsn_pkg::STEP_W'(hsn_pkg::DIVD_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[hsn_pkg::DIVD_W-2:0], 1'b0};
         quo_ff <= {quo_ff[hsn_pkg::Q_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: hdl/hamming_set_nearness_unit.sv
// top level of the hamming set nearness unit: stores, sequencer and result register
//
// usage
// - req channel (req_valid / req_stall / req_data) takes one word per cycle unless
//   stalled: load a, load b or compute, plus vector for loads; action 3 is dropped
// - loads go straight into a 256 x 64 store per set; a load into a full set is
//   dropped and remembered as overflow for the next compute
// - compute walks both stores through a row of 8 cells and gives one rsp word
//   (status, nearness in q16) on the rsp channel; both sets are cleared at accept
// - throughput one load per cycle while req_stall is low
// - compute: pass a against b, then pass b against a, each in batches of 8 source
//   vectors held in the cells while the other set streams past; then the multiply
//   states, the divider and the result register; the walk is paced by the cell row
//   width and the single read port of each store. an empty set skips to S_DONE
// - req_stall is high from the accepted compute until its result is registered
// - while rsp_stall holds, the result word stays; the unit can still take loads
// - csr index 0 sets vector_length, 1 affinity_mode; user: idle only, not enforced
// - reset (synchronous) empties both sets, clears overflow and restores the
//   registers to length 64 and distance mode; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module hamming_set_nearness_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire hsn_pkg::hsn_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output hsn_pkg::hsn_rsp_type                     rsp_data,
   input  wire logic                                csr_write_en,
   input  wire logic [hsn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hsn_pkg::LEN_W-1:0]           csr_data
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SHIFT  = 4'd1;
   localparam logic [3:0] S_STREAM = 4'd2;
   localparam logic [3:0] S_WAIT   = 4'd3;
   localparam logic [3:0] S_MUL1   = 4'd4;
   localparam logic [3:0] S_MUL2   = 4'd5;
   localparam logic [3:0] S_MUL3   = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // configuration
   logic [hsn_pkg::LEN_W-1:0]    len_cfg_ff;
   logic                         aff_cfg_ff;
   logic [hsn_pkg::LEN_W-1:0]    len_eff;

   // set stores
   logic [hsn_pkg::VEC_BITS-1:0] store_a [hsn_pkg::MAX_SET];
   logic [hsn_pkg::VEC_BITS-1:0] store_b [hsn_pkg::MAX_SET];
   logic [hsn_pkg::VEC_BITS-1:0] a_q_ff;
   logic [hsn_pkg::VEC_BITS-1:0] b_q_ff;
   logic [hsn_pkg::ADDR_W-1:0]   rd_addr_a;
   logic [hsn_pkg::ADDR_W-1:0]   rd_addr_b;
   logic                         wr_a;
   logic                         wr_b;

   // sequencer control
   logic [3:0]                   state_ff, state_in;
   // previous state, used to find the first cycle in the divide state
   logic [3:0]                   state_prev_ff;
   logic                         pass_ff, pass_in;
   logic                         final_ff, final_in;
   logic [hsn_pkg::SEQ_W-1:0]    base_ff, base_in;
   logic [hsn_pkg::SEQ_W-1:0]    cnt_ff, cnt_in;
   logic [hsn_pkg::CNT_W-1:0]    na_ff, na_in;
   logic [hsn_pkg::CNT_W-1:0]    nb_ff, nb_in;
   logic                         ovf_ff, ovf_in;
   logic [hsn_pkg::CNT_W-1:0]    wna_ff, wna_in;
   logic [hsn_pkg::CNT_W-1:0]    wnb_ff, wnb_in;
   logic                         wovf_ff, wovf_in;
   logic                         shift_p_ff;
   logic                         srcv_p_ff;
   logic                         dstv_p_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   logic                         div_start;
   logic                         div_done;

   // arithmetic
   logic [hsn_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_plus;
   logic [hsn_pkg::SUM_W-1:0]    sa_ff, sa_in;
   logic [hsn_pkg::SUM_W-1:0]    sb_ff, sb_in;
   logic [hsn_pkg::PROD_W-1:0]   p1_ff, p1_in;
   logic [hsn_pkg::PROD_W-1:0]   p2_ff, p2_in;
   logic [hsn_pkg::DD_W-1:0]     dd_ff, dd_in;
   logic [hsn_pkg::DEN_W-1:0]    num_ff, num_in;
   logic [hsn_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [1:0]                   status_ff, status_in;
   logic [hsn_pkg::Q_W-1:0]      quot;
   hsn_pkg::hsn_rsp_type         rsp_data_ff, rsp_data_in;

   // walk signals
   logic                         req_fire;
   logic [hsn_pkg::CNT_W-1:0]    ns;
   logic [hsn_pkg::CNT_W-1:0]    nd;
   logic [hsn_pkg::SEQ_W-1:0]    src_idx;
   logic [hsn_pkg::SEQ_W-1:0]    base_next;
   logic                         srcv_issue;
   logic                         dstv_issue;
   hsn_pkg::hsn_ctl_type         row_ctl;
   hsn_pkg::hsn_link_type        row_head;
   hsn_pkg::hsn_link_type        row_tail;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign len_eff   = hsn_pkg::eff_len(len_cfg_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= hsn_pkg::LEN_W'(hsn_pkg::VEC_BITS);
         aff_cfg_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            hsn_pkg::CSR_VECTOR_LENGTH: len_cfg_ff <= csr_data;
            hsn_pkg::CSR_AFFINITY_MODE: aff_cfg_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pass 0 runs a against b, pass 1 runs b against a
   always_comb begin
      ns         = pass_ff ? wnb_ff : wna_ff;
      nd         = pass_ff ? wna_ff : wnb_ff;
      src_idx    = base_ff + cnt_ff;
      base_next  = base_ff + hsn_pkg::SEQ_W'(hsn_pkg::NCELL);
      srcv_issue = (state_ff == S_SHIFT) && !final_ff
                   && (src_idx < hsn_pkg::SEQ_W'(ns));
      dstv_issue = (state_ff == S_STREAM) && (cnt_ff < hsn_pkg::SEQ_W'(nd));
      rd_addr_a  = pass_ff ? cnt_ff[hsn_pkg::ADDR_W-1:0] : src_idx[hsn_pkg::ADDR_W-1:0];
      rd_addr_b  = pass_ff ? src_idx[hsn_pkg::ADDR_W-1:0] : cnt_ff[hsn_pkg::ADDR_W-1:0];
      wr_a       = req_fire && (req_data.action == hsn_pkg::ACT_LOAD_A)
                   && (na_ff < hsn_pkg::CNT_W'(hsn_pkg::MAX_SET));
      wr_b       = req_fire && (req_data.action == hsn_pkg::ACT_LOAD_B)
                   && (nb_ff < hsn_pkg::CNT_W'(hsn_pkg::MAX_SET));
   end

   // stores: one write port for loads, one registered read port for the walk
   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a[na_ff[hsn_pkg::ADDR_W-1:0]] <= req_data.vector;
      end
      a_q_ff <= store_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         store_b[nb_ff[hsn_pkg::ADDR_W-1:0]] <= req_data.vector;
      end
      b_q_ff <= store_b[rd_addr_b];
   end

   // cell row, fed in the cycle after the read issue
   always_comb begin
      row_ctl.shift = shift_p_ff;
      row_ctl.mask  = hsn_pkg::len_mask(len_eff);
      row_head.src  = pass_ff ? b_q_ff : a_q_ff;
      row_head.srcv = srcv_p_ff;
      row_head.dst  = pass_ff ? a_q_ff : b_q_ff;
      row_head.dstv = dstv_p_ff;
      row_head.min  = hsn_pkg::MIN_INIT;
   end

   hsn_cell_row u_row (
      .clock (clock),
      .reset (reset),
      .ctl   (row_ctl),
      .head  (row_head),
      .tail  (row_tail)
   );

   // minimums leave the tail cell while the next batch shifts in
   assign sum_plus = (shift_p_ff && row_tail.srcv)
                   ? sum_ff + hsn_pkg::SUM_W'(row_tail.min) : sum_ff;

   hsn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_ff, hsn_pkg::FRAC_BITS'(0)}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      final_in    = final_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      na_in       = na_ff;
      nb_in       = nb_ff;
      ovf_in      = ovf_ff;
      wna_in      = wna_ff;
      wnb_in      = wnb_ff;
      wovf_in     = wovf_ff;
      sum_in      = sum_plus;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      dd_in       = dd_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      status_in   = status_ff;
      div_start   = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.action)
                  hsn_pkg::ACT_LOAD_A: begin
                     if (wr_a) na_in = na_ff + 1'b1;
                     else      ovf_in = 1'b1;
                  end
                  hsn_pkg::ACT_LOAD_B: begin
                     if (wr_b) nb_in = nb_ff + 1'b1;
                     else      ovf_in = 1'b1;
                  end
                  hsn_pkg::ACT_COMPUTE: begin
                     wna_in  = na_ff;
                     wnb_in  = nb_ff;
                     wovf_in = ovf_ff;
                     na_in   = '0;
                     nb_in   = '0;
                     ovf_in  = 1'b0;
                     if ((na_ff == '0) || (nb_ff == '0)) begin
                        status_in = hsn_pkg::STATUS_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        pass_in  = 1'b0;
                        final_in = 1'b0;
                        base_in  = '0;
                        cnt_in   = '0;
                        sum_in   = '0;
                        state_in = S_SHIFT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SHIFT: begin
            if (cnt_ff == hsn_pkg::SEQ_W'(hsn_pkg::NCELL - 1)) begin
               cnt_in   = '0;
               state_in = final_ff ? S_WAIT : S_STREAM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_STREAM: begin
            if (cnt_ff == hsn_pkg::SEQ_W'(nd) + hsn_pkg::SEQ_W'(hsn_pkg::NCELL - 1)) begin
               cnt_in   = '0;
               base_in  = base_next;
               final_in = (base_next >= hsn_pkg::SEQ_W'(ns));
               state_in = S_SHIFT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WAIT: begin
            // last minimum of the pass lands in sum_plus this cycle
            if (!pass_ff) begin
               sa_in    = sum_plus;
               pass_in  = 1'b1;
               final_in = 1'b0;
               base_in  = '0;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = S_SHIFT;
            end else begin
               sb_in    = sum_plus;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            p1_in    = hsn_pkg::PROD_W'(sa_ff) * hsn_pkg::PROD_W'(wnb_ff);
            p2_in    = hsn_pkg::PROD_W'(sb_ff) * hsn_pkg::PROD_W'(wna_ff);
            dd_in    = hsn_pkg::DD_W'(wna_ff) * hsn_pkg::DD_W'(wnb_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            num_in   = hsn_pkg::DEN_W'(p1_ff) + hsn_pkg::DEN_W'(p2_ff);
            den_in   = aff_cfg_ff
                     ? hsn_pkg::DEN_W'({dd_ff, 1'b0}) * hsn_pkg::DEN_W'(len_eff)
                     : hsn_pkg::DEN_W'({dd_ff, 1'b0});
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (aff_cfg_ff) begin
               num_in = den_ff - num_ff;
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               status_in = wovf_ff ? hsn_pkg::STATUS_OVERFLOW : hsn_pkg::STATUS_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // divider starts once the final numerator is registered
      div_start = (state_ff == S_DIV) && (state_ff != state_prev_ff);
   end

   always_comb begin
      rsp_valid_in         = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in.status   = status_ff;
      rsp_data_in.nearness = (status_ff == hsn_pkg::STATUS_EMPTY) ? '0 : quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         state_prev_ff <= S_IDLE;
         pass_ff       <= 1'b0;
         final_ff      <= 1'b0;
         base_ff       <= '0;
         cnt_ff        <= '0;
         na_ff         <= '0;
         nb_ff         <= '0;
         ovf_ff        <= 1'b0;
         wna_ff        <= '0;
         wnb_ff        <= '0;
         wovf_ff       <= 1'b0;
         status_ff     <= hsn_pkg::STATUS_OK;
         shift_p_ff    <= 1'b0;
         srcv_p_ff     <= 1'b0;
         dstv_p_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         state_prev_ff <= state_ff;
         pass_ff       <= pass_in;
         final_ff      <= final_in;
         base_ff       <= base_in;
         cnt_ff        <= cnt_in;
         na_ff         <= na_in;
         nb_ff         <= nb_in;
         ovf_ff        <= ovf_in;
         wna_ff        <= wna_in;
         wnb_ff        <= wnb_in;
         wovf_ff       <= wovf_in;
         status_ff     <= status_in;
         shift_p_ff    <= (state_ff == S_SHIFT);
         srcv_p_ff     <= srcv_issue;
         dstv_p_ff     <= dstv_issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      dd_ff  <= dd_in;
      num_ff <= num_in;
      den_ff <= den_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hdl/hsn_checker.sv
// port-level checker for the hamming set nearness unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "hamming_set_nearness_unit_assert.svh"
module hsn_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire hsn_pkg::hsn_req_type            req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire hsn_pkg::hsn_rsp_type            rsp_data
);

   // result word holds while stalled
   `HSN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // empty set reports zero nearness
   `HSN_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && (rsp_data.status == hsn_pkg::STATUS_EMPTY), rsp_data.nearness == '0, "empty status with nonzero nearness")

   // an accepted compute blocks the next word
   `HSN_ASSERT_NEXT(a_compute_busy, clock, reset, req_valid && !req_stall && (req_data.action == hsn_pkg::ACT_COMPUTE), req_stall, "word taken right after a compute")

   // reset leaves the unit idle and empty on the result side
   `HSN_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "unit not idle after reset")

endmodule

bind hamming_set_nearness_unit hsn_checker u_hsn_checker (.*);
`default_nettype wire

FILE: dv/hamming_set_nearness_checker.sv
// channel monitor, nearness predictor and result comparator for the hamming set nearness unit
`timescale 1ns / 1ps
module hamming_set_nearness_checker
   import hsn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  hsn_req_type          req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  hsn_rsp_type          rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   pending
);

   logic [VEC_BITS-1:0] set_a_vecs [MAX_SET];
   logic [VEC_BITS-1:0] set_b_vecs [MAX_SET];
   int                  a_count;
   int                  b_count;
   bit                  overflow_flag;
   logic [LEN_W-1:0]    length_reg;
   bit                  affinity_reg;
   hsn_rsp_type         expected_words[$];

   assign pending = expected_words.size();

   // sum over every src vector of its least masked distance to the dst set
   function automatic longint unsigned min_distance_sum(input bit from_a,
                                                        input logic [VEC_BITS-1:0] mask);
      longint unsigned sum;
      int              n_src;
      int              n_dst;
      int              best;
      int              d;
      logic [VEC_BITS-1:0] s;
      logic [VEC_BITS-1:0] t;
      sum = 0;
      n_src = from_a ? a_count : b_count;
      n_dst = from_a ? b_count : a_count;
      for (int i = 0; i < n_src; i++) begin
         s = from_a ? set_a_vecs[i] : set_b_vecs[i];
         best = VEC_BITS + 1;
         for (int j = 0; j < n_dst; j++) begin
            t = from_a ? set_b_vecs[j] : set_a_vecs[j];
            d = $countones((s ^ t) & mask);
            if (d < best) best = d;
         end
         sum += best;
      end
      return sum;
   endfunction

   function automatic hsn_rsp_type predict_nearness();
      hsn_rsp_type     w;
      int              l;
      logic [VEC_BITS-1:0] mask;
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      w.status = STATUS_EMPTY;
      w.nearness = '0;
      if (a_count != 0 && b_count != 0) begin
         l = int'(length_reg);
         if (l < 1) l = 1;
         if (l > VEC_BITS) l = VEC_BITS;
         mask = (l >= 64) ? '1 : ((64'd1 << l) - 64'd1);
         num = min_distance_sum(1'b1, mask) * longint'(b_count)
             + min_distance_sum(1'b0, mask) * longint'(a_count);
         den = 2 * longint'(a_count) * longint'(b_count);
         if (affinity_reg) begin
            den = den * longint'(l);
            num = den - num;
         end
         q = (num << FRAC_BITS) / den;
         w.nearness = q[Q_W-1:0];
         w.status = overflow_flag ? STATUS_OVERFLOW : STATUS_OK;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      hsn_rsp_type exp_word;
      if (reset) begin
         a_count = 0;
         b_count = 0;
         overflow_flag = 0;
         length_reg = LEN_W'(64);
         affinity_reg = 0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_VECTOR_LENGTH) length_reg = csr_data;
            else if (csr_index == CSR_AFFINITY_MODE) affinity_reg = csr_data[0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with none expected: status %0d nearness %0d",
                      rsp_data.status, rsp_data.nearness);
               fail_count++;
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_data.status !== exp_word.status) begin
                  $error("status: expected %0d, got %0d", exp_word.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.nearness !== exp_word.nearness) begin
                  $error("nearness: expected %0d, got %0d",
                         exp_word.nearness, rsp_data.nearness);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.action)
               ACT_LOAD_A: begin
                  if (a_count < MAX_SET) set_a_vecs[a_count++] = req_data.vector;
                  else overflow_flag = 1;
               end
               ACT_LOAD_B: begin
                  if (b_count < MAX_SET) set_b_vecs[b_count++] = req_data.vector;
                  else overflow_flag = 1;
               end
               ACT_COMPUTE: begin
                  expected_words.push_back(predict_nearness());
                  a_count = 0;
                  b_count = 0;
                  overflow_flag = 0;
               end
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: dv/hamming_set_nearness_unit_tb.sv
// stimulus and verdict for the hamming set nearness unit
`timescale 1ns / 1ps
module hamming_set_nearness_unit_tb;
   import hsn_pkg::*;

   // action code the unit must drop silently
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   hsn_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   hsn_rsp_type          rsp_data;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0]     csr_data;
   int                   fail_count;
   int                   pending;

   // idle percentages of each side, changed at phases 3 and 6
   int send_idle_pct;
   int recv_idle_pct;
   // long receiver hold requested by the stimulus, in cycles
   int hold_request;
   int hold_left;
   int words_sent;

   hamming_set_nearness_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   hamming_set_nearness_checker nearness_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stall, or a long hold counted here
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one word and hold it until the unit takes it
   task automatic send_word(input logic [1:0] act, input logic [VEC_BITS-1:0] vec);
      req_valid <= 1'b1;
      req_data.action <= act;
      req_data.vector <= vec;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      words_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // vectors cluster around a base so that minimums spread over small distances
   function automatic logic [VEC_BITS-1:0] pick_vector(input logic [VEC_BITS-1:0] base);
      logic [VEC_BITS-1:0] v;
      v = base;
      case ($urandom_range(9))
         0: v = '0;
         1: v = '1;
         2, 3: v = {$urandom, $urandom};
         default: begin
            repeat ($urandom_range(0, 5)) v[$urandom_range(VEC_BITS - 1)] ^= 1'b1;
         end
      endcase
      return v;
   endfunction

   // one load burst of the given sizes in random order, stray unused actions, then a compute
   task automatic send_set_pair(input int na, input int nb);
      logic [VEC_BITS-1:0] base;
      int ia;
      int ib;
      base = {$urandom, $urandom};
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(19) == 0) send_word(ACT_UNUSED, {$urandom, $urandom});
         if (ib >= nb || (ia < na && $urandom_range(1))) begin
            send_word(ACT_LOAD_A, pick_vector(base));
            ia++;
         end else begin
            send_word(ACT_LOAD_B, pick_vector(base));
            ib++;
         end
      end
      send_word(ACT_COMPUTE, {$urandom, $urandom});
   endtask

   // configuration only while nothing is in flight
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      req_valid <= 1'b0;
      // wait for the clock so that a compute taken just now is counted as pending
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [LEN_W-1:0] lengths [9];
      int goal;
      lengths = '{7'd64, 7'd1, 7'd0, 7'd33, 7'd127, 7'd7, 7'd64, 7'd20, 7'd65};
      clock = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 28;
      recv_idle_pct = 61;
      hold_request = 0;
      hold_left = 0;
      words_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, empty sets, extreme vectors, unused action
      send_word(ACT_COMPUTE, '0);
      send_word(ACT_LOAD_A, '1);
      send_word(ACT_COMPUTE, '1);
      send_word(ACT_LOAD_B, '0);
      send_word(ACT_COMPUTE, '0);
      send_word(ACT_LOAD_A, '0);
      send_word(ACT_LOAD_B, '1);
      send_word(ACT_UNUSED, '1);
      send_word(ACT_COMPUTE, '0);
      send_word(ACT_LOAD_A, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(ACT_LOAD_A, 64'h5555_5555_5555_5555);
      send_word(ACT_LOAD_B, 64'h8000_0000_0000_0001);
      send_word(ACT_UNUSED, '0);
      send_word(ACT_COMPUTE, '0);
      write_csr(CSR_AFFINITY_MODE, 7'h7F);
      send_word(ACT_LOAD_A, '1);
      send_word(ACT_LOAD_B, '1);
      send_word(ACT_COMPUTE, '0);
      send_word(ACT_LOAD_A, '0);
      send_word(ACT_LOAD_B, '1);
      send_word(ACT_COMPUTE, '0);

      // random phases, one setting each; idling pattern moves through thirds
      for (int p = 0; p < 9; p++) begin
         if (p == 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 28;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_VECTOR_LENGTH, lengths[p]);
         write_csr(CSR_AFFINITY_MODE, LEN_W'(p % 2 + 2 * (p % 3)));
         goal = words_sent + 50;
         while (words_sent < goal) begin
            case ($urandom_range(19))
               0: send_set_pair(0, $urandom_range(0, 3));
               1: send_set_pair($urandom_range(1, 3), 0);
               2: send_set_pair($urandom_range(9, 40), $urandom_range(9, 40));
               default: send_set_pair($urandom_range(1, 8), $urandom_range(1, 8));
            endcase
         end
         // overflow of both sets, with a long receiver hold under a full input
         if (p == 4) begin
            send_set_pair(MAX_SET + 2, 1);
            send_set_pair(2, MAX_SET + 1);
         end
         if (p == 7) begin
            hold_request = 400;
            repeat (6) send_set_pair($urandom_range(1, 4), $urandom_range(1, 4));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
